// ----- rtl/positional_list_engine_top_macros.svh -----
// assertion helpers for the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// condition holds in the same cycle
`define PLIST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define PLIST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/plist_pkg.sv -----
package plist_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 7;
    localparam int PW       = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_READ   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAB,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_DRAIN,
        ST_PUT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

// ----- rtl/positional_list_engine_top.sv -----
// positional list engine: an ordered list of up to 64 signed 32-bit values
// input channel s_: one request item; s_tuser holds the request kind
// (insert, remove, read) and the at-tail flag, s_tdata the position and
// the value to insert; at_tail set selects the end of the list
// result channel m_: one item per request; m_tuser is ok, m_tdata holds
// the removed or read value (zero on insert or failure) and the new count
// one request at a time: s_tready is high only while the engine is idle
// states from accept back to idle: rejected request RESULT; read LOAD,
//   GRAB, RESULT; insert at the end PUT, RESULT; other inserts SHIFT_UP
//   per moved entry, DRAIN, PUT, RESULT; remove LOAD, GRAB, SHIFT_DN per
//   moved entry and DRAIN if any move, RESULT; moves use the read and write
// memory ports; m_tvalid rises at the edge that returns the engine to idle
// a held result sits in the output register and the next request is
// still taken; a further result waits until m_tready frees that register
// reset empties the list at once; memory contents are not cleared
`include "positional_list_engine_top_macros.svh"

module positional_list_engine_top import plist_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[6:0], data_in[38:7], pad
    input  logic [2:0]  s_tuser,   // req_type[1:0], at_tail[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data_out[31:0], count[38:32], pad
    output logic [0:0]  m_tuser    // ok[0]
);

    mem_req_t           mem_req;
    logic [DATA_W-1:0]  mem_rdata;
    logic               res_load;
    logic               res_free;
    res_t               res;
    logic               out_ok;
    logic [DATA_W-1:0]  out_data;
    logic [COUNT_W-1:0] out_count;
    logic               in_take;
    logic               res_fail;
    logic               count_ok;

    plist_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_kind    (s_tuser[1:0]),
        .s_tail    (s_tuser[2]),
        .s_pos     (s_tdata[6:0]),
        .s_value   (s_tdata[38:7]),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_load  (res_load),
        .res       (res),
        .res_free  (res_free)
    );

    plist_store u_store (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    plist_oreg u_oreg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res      (res),
        .free     (res_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_ok     (out_ok),
        .m_data   (out_data),
        .m_count  (out_count)
    );

    assign m_tuser = out_ok;
    assign m_tdata = {1'b0, out_count, out_data};

    assign in_take  = s_tvalid && s_tready;
    assign res_fail = m_tvalid && !out_ok;
    assign count_ok = (out_count <= COUNT_W'(CAPACITY));

    `PLIST_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, in_take, !s_tready, "taken while busy")
    `PLIST_ASSERT_NOW(a_fail_zero, aclk, aresetn, res_fail, out_data == '0, "data on refusal")
    `PLIST_ASSERT_NOW(a_count_range, aclk, aresetn, m_tvalid, count_ok, "count above capacity")

endmodule

// ----- rtl/plist_store.sv -----
module plist_store import plist_pkg::*; (
    input  logic              aclk,
    input  mem_req_t          mem_req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rdata_reg <= mem[mem_req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/plist_oreg.sv -----
module plist_oreg import plist_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  res_t               res,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_ok,
    output logic [DATA_W-1:0]  m_data,
    output logic [COUNT_W-1:0] m_count
);

    logic valid_reg;
    res_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_ok     = res_reg.ok;
    assign m_data   = res_reg.data;
    assign m_count  = res_reg.count;

endmodule

// ----- rtl/plist_ctrl.sv -----
module plist_ctrl import plist_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic              s_tail,
    input  logic [POS_W-1:0]  s_pos,
    input  logic [DATA_W-1:0] s_value,
    output mem_req_t          mem_req,
    input  logic [DATA_W-1:0] mem_rdata,
    output logic              res_load,
    output res_t              res,
    input  logic              res_free
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic                ok_reg;
    logic [ADDR_W-1:0]   pos_reg;
    logic [ADDR_W-1:0]   ptr_reg;
    logic                pend_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [DATA_W-1:0]   got_reg;

    logic                accept;
    logic [PW-1:0]       cnt_x, pos_x, ins_p, get_p;
    logic                ins_ok, get_ok, ok_in, ins_at_end;
    logic [ADDR_W-1:0]   pos_in;
    logic [CNT_W-1:0]    cnt_m1, pos_p1, cnt_new;
    logic [ADDR_W-1:0]   last_dn;
    logic                more_dn;

    // request decode against the current fill level
    always_comb begin
        cnt_x      = PW'(cnt_reg);
        pos_x      = PW'(s_pos);
        ins_p      = s_tail ? cnt_x : pos_x;
        get_p      = s_tail ? (cnt_x - PW'(1)) : pos_x;
        ins_ok     = (ins_p <= cnt_x) && (cnt_reg < CNT_W'(CAPACITY));
        get_ok     = (cnt_reg != '0) && (get_p < cnt_x);
        ins_at_end = (ins_p == cnt_x);
        unique case (s_kind) inside
            REQ_INSERT: begin
                ok_in  = ins_ok;
                pos_in = ins_p[ADDR_W-1:0];
            end
            REQ_REMOVE, REQ_READ: begin
                ok_in  = get_ok;
                pos_in = get_p[ADDR_W-1:0];
            end
            default: begin
                ok_in  = 1'b0;
                pos_in = '0;
            end
        endcase
    end

    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign pos_p1  = CNT_W'(pos_reg) + CNT_W'(1);
    assign last_dn = cnt_m1[ADDR_W-1:0];
    assign more_dn = (kind_reg == REQ_REMOVE) && (pos_p1 < cnt_reg);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cnt_new = cnt_reg;
        if (ok_reg && kind_reg == REQ_INSERT) begin
            cnt_new = cnt_reg + CNT_W'(1);
        end else if (ok_reg && kind_reg == REQ_REMOVE) begin
            cnt_new = cnt_m1;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!ok_in) begin
                        state_next = ST_RESULT;
                    end else if (s_kind == REQ_INSERT) begin
                        state_next = ins_at_end ? ST_PUT : ST_SHIFT_UP;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:     state_next = ST_GRAB;
            ST_GRAB:     state_next = more_dn ? ST_SHIFT_DN : ST_RESULT;
            ST_SHIFT_UP: state_next = (ptr_reg == pos_reg) ? ST_DRAIN : ST_SHIFT_UP;
            ST_SHIFT_DN: state_next = (ptr_reg == last_dn) ? ST_DRAIN : ST_SHIFT_DN;
            ST_DRAIN:    state_next = (kind_reg == REQ_INSERT) ? ST_PUT : ST_RESULT;
            ST_PUT:      state_next = ST_RESULT;
            ST_RESULT:   state_next = res_free ? ST_IDLE : ST_RESULT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = 1'b0;
        res_load      = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = pend_addr_reg;
        mem_req.wdata = mem_rdata;
        mem_req.raddr = ptr_reg;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_LOAD: mem_req.raddr = pos_reg;
            ST_SHIFT_UP, ST_SHIFT_DN, ST_DRAIN: mem_req.we = pend_reg;
            ST_PUT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = value_reg;
            end
            ST_RESULT: res_load = res_free;
            default: ;
        endcase
    end

    assign res.ok    = ok_reg;
    assign res.data  = got_reg;
    assign res.count = COUNT_W'(cnt_new);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SHIFT_UP) || (state_reg == ST_SHIFT_DN);
            if (res_load) begin
                cnt_reg <= cnt_new;
            end
        end
    end

    // request and move pointers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_reg  <= s_kind;
                    ok_reg    <= ok_in;
                    pos_reg   <= pos_in;
                    value_reg <= s_value;
                    got_reg   <= '0;
                    ptr_reg   <= cnt_m1[ADDR_W-1:0];
                end
            end
            ST_GRAB: begin
                got_reg <= mem_rdata;
                ptr_reg <= pos_p1[ADDR_W-1:0];
            end
            ST_SHIFT_UP: begin
                pend_addr_reg <= ptr_reg + ADDR_W'(1);
                ptr_reg       <= ptr_reg - ADDR_W'(1);
            end
            ST_SHIFT_DN: begin
                pend_addr_reg <= ptr_reg - ADDR_W'(1);
                ptr_reg       <= ptr_reg + ADDR_W'(1);
            end
            default: ;
        endcase
    end

endmodule
